// ===== rtl/sofp_pkg.sv =====
package sofp_pkg;

  localparam logic [7:0] HdrByte0 = 8'h3C;  // '<'
  localparam logic [7:0] HdrByte1 = 8'h7B;  // '{'
  localparam logic [7:0] HdrByte2 = 8'h28;  // '('
  localparam logic [7:0] CrByte   = 8'h0D;
  localparam logic [7:0] LfByte   = 8'h0A;

  typedef enum logic [3:0] {
    SecHunt0  = 4'd0,
    SecHunt1  = 4'd1,
    SecHunt2  = 4'd2,
    SecId     = 4'd3,
    SecInstLo = 4'd4,
    SecInstHi = 4'd5,
    SecLength = 4'd6,
    SecBody   = 4'd7,
    SecCr     = 4'd8,
    SecLf     = 4'd9
  } section_e;

  typedef enum logic [1:0] {
    KindBody     = 2'd0,
    KindComplete = 2'd1,
    KindDropped  = 2'd2
  } kind_e;

  typedef struct packed {
    section_e    section;
    logic [7:0]  held_id;
    logic [15:0] held_instance;
    logic [7:0]  held_length;
    logic [7:0]  body_count;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic [7:0]  object_id;
    logic [15:0] instance_number;
    logic [7:0]  body_length;
  } result_t;

endpackage

// ===== rtl/sofp_step.sv =====
module sofp_step (
  input  sofp_pkg::parse_state_t state_i,
  input  logic [7:0]             rx_byte_i,
  output sofp_pkg::parse_state_t state_o,
  output sofp_pkg::result_t      result_o
);
  import sofp_pkg::*;

  logic [8:0] count_inc;

  assign count_inc = {1'b0, state_i.body_count} + 9'd1;

  always_comb begin
    state_o                  = state_i;
    result_o.valid           = 1'b0;
    result_o.kind            = KindBody;
    result_o.data_byte       = 8'd0;
    result_o.position        = 8'd0;
    result_o.object_id       = state_i.held_id;
    result_o.instance_number = state_i.held_instance;
    result_o.body_length     = state_i.held_length;

    unique case (state_i.section)
      SecHunt0: begin
        state_o.body_count = 8'd0;
        state_o.section    = (rx_byte_i == HdrByte0) ? SecHunt1 : SecHunt0;
      end
      SecHunt1: begin
        state_o.body_count = 8'd0;
        state_o.section    = (rx_byte_i == HdrByte1) ? SecHunt2 : SecHunt0;
      end
      SecHunt2: begin
        state_o.body_count = 8'd0;
        state_o.section    = (rx_byte_i == HdrByte2) ? SecId : SecHunt0;
      end
      SecId: begin
        state_o.held_id = rx_byte_i;
        state_o.section = SecInstLo;
      end
      SecInstLo: begin
        state_o.held_instance = {8'd0, rx_byte_i};
        state_o.section       = SecInstHi;
      end
      SecInstHi: begin
        state_o.held_instance = {rx_byte_i, state_i.held_instance[7:0]};
        state_o.section       = SecLength;
      end
      SecLength: begin
        state_o.held_length = rx_byte_i;
        state_o.section     = SecBody;
      end
      SecBody: begin
        result_o.valid     = 1'b1;
        result_o.kind      = KindBody;
        result_o.data_byte = rx_byte_i;
        result_o.position  = state_i.body_count;
        state_o.body_count = count_inc[7:0];
        // zero length still ends after one byte
        if (count_inc >= {1'b0, state_i.held_length}) begin
          state_o.section = SecCr;
        end
      end
      SecCr: begin
        if (rx_byte_i == CrByte) begin
          state_o.section = SecLf;
        end else begin
          result_o.valid     = 1'b1;
          result_o.kind      = KindDropped;
          state_o.section    = SecHunt0;
          state_o.body_count = 8'd0;
        end
      end
      SecLf: begin
        result_o.valid     = 1'b1;
        result_o.kind      = (rx_byte_i == LfByte) ? KindComplete : KindDropped;
        state_o.section    = SecHunt0;
        state_o.body_count = 8'd0;
      end
      default: begin
        state_o.section    = SecHunt0;
        state_o.body_count = 8'd0;
      end
    endcase
  end

endmodule

// ===== rtl/serial_object_frame_parser.sv =====
// a body, complete or dropped result is shown in the cycle after its byte is accepted
// throughput: one byte per cycle; the single result register is refilled in the cycle
//   it is drained, so the input stalls only while a result waits unaccepted
// reset: parser returns to hunting the first header byte, held fields clear to zero,
//   no result pending
module serial_object_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  position_o,
  output logic [7:0]  object_id_o,
  output logic [15:0] instance_number_o,
  output logic [7:0]  body_length_o
);
  import sofp_pkg::*;

  parse_state_t state_q, state_d;
  result_t      step_res;
  result_t      res_q;
  logic         out_valid_q;
  logic         in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  sofp_step u_step (
    .state_i   (state_q),
    .rx_byte_i (rx_byte_i),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{section: SecHunt0, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= step_res.valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (in_fire && step_res.valid) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign data_byte_o       = res_q.data_byte;
  assign position_o        = res_q.position;
  assign object_id_o       = res_q.object_id;
  assign instance_number_o = res_q.instance_number;
  assign body_length_o     = res_q.body_length;

endmodule
